### hw/rtl/psfa_pkg.sv
// shared types and constants for the particle sensor frame averager
// no dependencies; imported by every module of the block
`default_nettype none
package psfa_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int CHECKED_BYTES = 30;
  localparam int VALUE_COUNT   = 6;
  localparam int POS_W         = 6;
  localparam int CSUM_W        = 13;
  localparam int VALUE_W       = 16;
  localparam int SUM_W         = 24;
  localparam int COUNT_W       = 8;
  localparam int DIV_CNT_W     = $clog2(SUM_W);
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [0:0] REG_SAMPLES_PER_AVERAGE = 1'b0;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_HEADER   = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  localparam logic [7:0] HEADER_0 = 8'h42;
  localparam logic [7:0] HEADER_1 = 8'h4D;
  localparam logic [7:0] HEADER_2 = 8'h00;
  localparam logic [7:0] HEADER_3 = 8'h1C;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } psfa_in_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic               average_ready;
    logic [VALUE_W-1:0] avg_pm1_std;
    logic [VALUE_W-1:0] avg_pm25_std;
    logic [VALUE_W-1:0] avg_pm10_std;
    logic [VALUE_W-1:0] avg_pm1_atm;
    logic [VALUE_W-1:0] avg_pm25_atm;
    logic [VALUE_W-1:0] avg_pm10_atm;
  } psfa_out_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_done;
  } psfa_cmd_t;

  typedef struct packed {
    logic last;
    logic avg_due;
  } psfa_sts_t;

  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HEADER_0;
      2'd1:    b = HEADER_1;
      2'd2:    b = HEADER_2;
      default: b = HEADER_3;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/psfa_ctrl.sv
// controller for the frame averager: handshakes, divide sequencing, result valid
// depends on psfa_pkg; drives commands into psfa_datapath
`default_nettype none
module psfa_ctrl
  import psfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire psfa_sts_t sts,
  output psfa_cmd_t      cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_fire, out_take, load;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    load         = 1'b0;
    cmd.accept   = in_fire;
    cmd.div_step = 1'b0;
    cmd.div_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && sts.last) begin
          if (sts.avg_due) begin
            state_nxt = S_DIV;
            cnt_nxt   = '0;
          end else begin
            load = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.div_done = 1'b1;
        load         = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/psfa_datapath.sv
// datapath for the frame averager: byte parsing, checksum, sums, shared divider
// depends on psfa_pkg; commanded by psfa_ctrl
`default_nettype none
module psfa_datapath
  import psfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psfa_in_t           in_data,
  input  wire logic [COUNT_W-1:0] samples_per_average,
  input  wire psfa_cmd_t          cmd,
  output psfa_sts_t               sts,
  output psfa_out_t               out_data
);

  logic [POS_W-1:0]   pos_r;
  logic               hdr_good_r;
  logic [CSUM_W-1:0]  csum_r;
  logic [7:0]         chk_hi_r;
  logic [VALUE_W-1:0] cap_r [VALUE_COUNT];
  logic [SUM_W-1:0]   sum_r [VALUE_COUNT];
  logic [COUNT_W-1:0] frames_r;
  logic [SUM_W-1:0]   quo_r [VALUE_COUNT];
  logic [7:0]         rem_r [VALUE_COUNT];
  logic [COUNT_W-1:0] divisor_r;
  psfa_out_t          out_r;

  logic [7:0]         b;
  logic               in_frame, hdr_bad_now;
  logic [2:0]         cap_idx;
  logic [POS_W-1:0]   cap_off;
  logic [1:0]         status;
  logic               good;
  logic [COUNT_W-1:0] frames_inc;
  logic [SUM_W-1:0]   sum_acc [VALUE_COUNT];
  logic [8:0]         trial   [VALUE_COUNT];
  logic               ge      [VALUE_COUNT];

  assign b        = in_data.rx_byte;
  assign in_frame = pos_r < POS_W'(FRAME_BYTES);
  assign cap_off  = pos_r - POS_W'(4);
  assign cap_idx  = cap_off[3:1];
  assign hdr_bad_now = (pos_r < POS_W'(4)) && (b != header_byte(pos_r[1:0]));

  always_comb begin
    if (pos_r != POS_W'(FRAME_BYTES - 1)) begin
      status = ST_LENGTH;
    end else if (!hdr_good_r) begin
      status = ST_HEADER;
    end else if ((chk_hi_r != {3'b000, csum_r[CSUM_W-1:8]}) || (b != csum_r[7:0])) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_GOOD;
    end
  end

  assign good       = (status == ST_GOOD);
  assign frames_inc = (frames_r == COUNT_MAX) ? frames_r : frames_r + 1'b1;

  assign sts.last    = in_data.chunk_last;
  assign sts.avg_due = in_data.chunk_last && good && (frames_inc >= samples_per_average);

  always_comb begin
    for (int j = 0; j < VALUE_COUNT; j++) begin
      sum_acc[j] = sum_r[j] + SUM_W'(cap_r[j]);
      trial[j]   = {rem_r[j], quo_r[j][SUM_W-1]};
      ge[j]      = trial[j] >= {1'b0, divisor_r};
    end
  end

  // chunk parsing and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hdr_good_r <= 1'b1;
      csum_r     <= '0;
      chk_hi_r   <= '0;
      frames_r   <= '0;
      for (int j = 0; j < VALUE_COUNT; j++) begin
        sum_r[j] <= '0;
      end
    end else if (cmd.accept) begin
      if (in_data.chunk_last) begin
        pos_r      <= '0;
        hdr_good_r <= 1'b1;
        csum_r     <= '0;
        chk_hi_r   <= '0;
        if (good) begin
          if (sts.avg_due) begin
            frames_r <= '0;
            for (int j = 0; j < VALUE_COUNT; j++) begin
              sum_r[j] <= '0;
            end
          end else begin
            frames_r <= frames_inc;
            for (int j = 0; j < VALUE_COUNT; j++) begin
              sum_r[j] <= sum_acc[j];
            end
          end
        end
      end else begin
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 1'b1;
        end
        if (in_frame && hdr_bad_now) begin
          hdr_good_r <= 1'b0;
        end
        if (pos_r < POS_W'(CHECKED_BYTES)) begin
          csum_r <= csum_r + CSUM_W'(b);
        end
        if (pos_r == POS_W'(CHECKED_BYTES)) begin
          chk_hi_r <= b;
        end
      end
    end
  end

  // captured concentrations, big-endian pairs from bytes 4 to 15
  always_ff @(posedge clk) begin
    if (cmd.accept && (pos_r >= POS_W'(4)) && (pos_r < POS_W'(16))) begin
      if (!pos_r[0]) begin
        cap_r[cap_idx][15:8] <= b;
      end else begin
        cap_r[cap_idx][7:0] <= b;
      end
    end
  end

  // restoring divider, one quotient bit per step on all six lanes
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.avg_due) begin
      divisor_r <= frames_inc;
      for (int j = 0; j < VALUE_COUNT; j++) begin
        quo_r[j] <= sum_acc[j];
        rem_r[j] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int j = 0; j < VALUE_COUNT; j++) begin
        quo_r[j] <= {quo_r[j][SUM_W-2:0], ge[j]};
        rem_r[j] <= ge[j] ? 8'(trial[j] - {1'b0, divisor_r}) : trial[j][7:0];
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.div_done) begin
      out_r.frame_status  <= ST_GOOD;
      out_r.average_ready <= 1'b1;
      out_r.avg_pm1_std   <= quo_r[0][VALUE_W-1:0];
      out_r.avg_pm25_std  <= quo_r[1][VALUE_W-1:0];
      out_r.avg_pm10_std  <= quo_r[2][VALUE_W-1:0];
      out_r.avg_pm1_atm   <= quo_r[3][VALUE_W-1:0];
      out_r.avg_pm25_atm  <= quo_r[4][VALUE_W-1:0];
      out_r.avg_pm10_atm  <= quo_r[5][VALUE_W-1:0];
    end else if (cmd.accept && in_data.chunk_last && !sts.avg_due) begin
      out_r <= '{frame_status: status, default: '0};
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### hw/rtl/particle_sensor_frame_averager.sv
// top level of the particle sensor frame averager: config register and wiring
// depends on psfa_pkg, psfa_ctrl and psfa_datapath
//
// usage
//   in channel: one received byte per request (in_data.rx_byte), with
//   in_data.chunk_last marking the final byte of a chunk. a request is taken
//   when in_valid is high and in_stall is low.
//   out channel: one result per chunk end (status, average_ready and six
//   averages), held in an output register until taken while out_stall is low.
//   config: samples_per_average at byte address 0, written through the apb
//   port while the block is idle; reads return its value.
//   throughput: one byte per cycle while in_stall is low. a chunk end that completes an average
//   runs the shared restoring divider, one quotient bit per cycle on six
//   lanes, and in_stall stays high through the divide and emit states.
//   result: a result is valid the cycle after its last byte is taken, or, when
//   an average is emitted, once the divide states and the emit state are through.
//   stall: while a result waits under out_stall, in_stall is high and no
//   byte is taken until the result leaves the output register.
//   reset: synchronous active-low rst_n clears the chunk parser, the sums,
//   the frame count and the output valid, and sets samples_per_average to 1.
`default_nettype none
module particle_sensor_frame_averager
  import psfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire psfa_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output psfa_out_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [COUNT_W-1:0] spa_r;
  logic               cfg_sel;
  psfa_cmd_t          cmd;
  psfa_sts_t          sts;
  logic               stall_raw;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_ADDR_W-1] == REG_SAMPLES_PER_AVERAGE);
  assign prdata  = cfg_sel ? CFG_DATA_W'(spa_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spa_r <= COUNT_W'(1);
    end else if (psel && penable && pwrite && cfg_sel) begin
      spa_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign in_stall = stall_raw;

  psfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (stall_raw),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psfa_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data             (in_data),
    .samples_per_average (spa_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_data            (out_data)
  );

endmodule
`default_nettype wire

### tb/sv/pm_average_checker.sv
// checker for the particle sensor frame averager: watches the byte, result and apb channels,
// predicts each chunk-end report and compares it field by field with what the block returns
// depends on psfa_pkg
module pm_average_checker
  import psfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  psfa_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  psfa_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] SPA_ADDR = CFG_ADDR_W'(4 * REG_SAMPLES_PER_AVERAGE);
  localparam logic [31:0] HDR_WORD = {HEADER_0, HEADER_1, HEADER_2, HEADER_3};

  logic [POS_W-1:0]   byte_pos;
  logic               hdr_ok;
  logic [CSUM_W-1:0]  csum;
  logic [7:0]         chk_hi;
  logic [VALUE_W-1:0] conc [VALUE_COUNT];
  logic [SUM_W-1:0]   sums [VALUE_COUNT];
  logic [COUNT_W-1:0] good_frames;
  logic [7:0]         samples_cfg;
  psfa_out_t          frame_reports_due [$];

  function automatic void absorb_rx_byte(input psfa_in_t req);
    logic [POS_W-1:0]   p;
    logic [VALUE_W-1:0] avg [VALUE_COUNT];
    psfa_out_t          rep;
    int                 k;
    p = byte_pos;
    if (p < FRAME_BYTES) begin
      if (p < 4 && req.rx_byte != HDR_WORD[31 - 8 * p -: 8]) hdr_ok = 1'b0;
      if (p < CHECKED_BYTES) csum = csum + CSUM_W'(req.rx_byte);
      if (p >= 4 && p < 16) begin
        k = (p - 4) >> 1;
        if (p[0] == 1'b0) conc[k][15:8] = req.rx_byte;
        else conc[k][7:0] = req.rx_byte;
      end
      if (p == CHECKED_BYTES) chk_hi = req.rx_byte;
    end
    if (byte_pos != POS_MAX) byte_pos++;
    if (!req.chunk_last) return;

    rep = '0;
    if (byte_pos != FRAME_BYTES) rep.frame_status = ST_LENGTH;
    else if (!hdr_ok) rep.frame_status = ST_HEADER;
    else if (chk_hi != 8'(csum >> 8) || req.rx_byte != csum[7:0])
      rep.frame_status = ST_CHECKSUM;
    else rep.frame_status = ST_GOOD;

    if (rep.frame_status == ST_GOOD) begin
      for (k = 0; k < VALUE_COUNT; k++) sums[k] = sums[k] + SUM_W'(conc[k]);
      if (good_frames != COUNT_MAX) good_frames++;
      if (good_frames >= samples_cfg) begin
        for (k = 0; k < VALUE_COUNT; k++) begin
          avg[k] = VALUE_W'(sums[k] / good_frames);
          sums[k] = '0;
        end
        good_frames = '0;
        rep.average_ready = 1'b1;
        rep.avg_pm1_std   = avg[0];
        rep.avg_pm25_std  = avg[1];
        rep.avg_pm10_std  = avg[2];
        rep.avg_pm1_atm   = avg[3];
        rep.avg_pm25_atm  = avg[4];
        rep.avg_pm10_atm  = avg[5];
      end
    end
    frame_reports_due.push_back(rep);
    byte_pos = '0;
    hdr_ok = 1'b1;
    csum = '0;
    chk_hi = '0;
  endfunction

  function automatic void check_report(input psfa_out_t got);
    psfa_out_t e;
    if (frame_reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: report with none outstanding: %h", $time, got);
      return;
    end
    e = frame_reports_due.pop_front();
    if (got.frame_status !== e.frame_status || got.average_ready !== e.average_ready ||
        got.avg_pm1_std !== e.avg_pm1_std || got.avg_pm25_std !== e.avg_pm25_std ||
        got.avg_pm10_std !== e.avg_pm10_std || got.avg_pm1_atm !== e.avg_pm1_atm ||
        got.avg_pm25_atm !== e.avg_pm25_atm || got.avg_pm10_atm !== e.avg_pm10_atm) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: report mismatch, exp status %0d ready %0d avg %h %h %h %h %h %h",
                 $time, e.frame_status, e.average_ready, e.avg_pm1_std, e.avg_pm25_std,
                 e.avg_pm10_std, e.avg_pm1_atm, e.avg_pm25_atm, e.avg_pm10_atm);
        $display("%0t: got status %0d ready %0d avg %h %h %h %h %h %h",
                 $time, got.frame_status, got.average_ready, got.avg_pm1_std,
                 got.avg_pm25_std, got.avg_pm10_std, got.avg_pm1_atm, got.avg_pm25_atm,
                 got.avg_pm10_atm);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      byte_pos = '0;
      hdr_ok = 1'b1;
      csum = '0;
      chk_hi = '0;
      for (int k = 0; k < VALUE_COUNT; k++) begin
        conc[k] = '0;
        sums[k] = '0;
      end
      good_frames = '0;
      samples_cfg = 8'd1;
      frame_reports_due.delete();
    end else begin
      if (out_valid && !out_stall) check_report(out_data);
      if (psel && penable && pwrite && pready && paddr == SPA_ADDR) samples_cfg = pwdata[7:0];
      if (in_valid && !in_stall) absorb_rx_byte(in_data);
    end
    pending = frame_reports_due.size();
  end

endmodule

### tb/sv/tb_top.sv
// top of the frame averager testbench: clock, reset, byte chunks, apb writes and back-pressure
// depends on psfa_pkg, particle_sensor_frame_averager and pm_average_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psfa_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] SPA_ADDR = CFG_ADDR_W'(4 * REG_SAMPLES_PER_AVERAGE);

  typedef enum int {
    CHUNK_GOOD, CHUNK_BAD_SUM, CHUNK_BAD_HDR, CHUNK_SHORT, CHUNK_LONG, CHUNK_NOISE
  } chunk_kind_t;

  typedef enum int {VAL_RANDOM, VAL_MAX, VAL_ZERO} value_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  psfa_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  psfa_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    pending;
  int                    snd_idle_pct;
  int                    rcv_idle_pct;
  int                    hold_cycles;
  int                    bytes_sent;

  particle_sensor_frame_averager u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pm_average_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side back-pressure, with an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rx_byte: b, chunk_last: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic logic [15:0] checksum_of(input logic [7:0] f [$]);
    logic [15:0] s;
    s = '0;
    for (int k = 0; k < CHECKED_BYTES; k++) s += f[k];
    return s;
  endfunction

  task automatic send_chunk(input chunk_kind_t kind, input value_mode_t vmode);
    logic [7:0]  f [$];
    logic [15:0] v;
    logic [15:0] word;
    int          n;
    int          idx;
    f = {HEADER_0, HEADER_1, HEADER_2, HEADER_3};
    for (int k = 0; k < VALUE_COUNT; k++) begin
      case (vmode)
        VAL_MAX:  v = 16'hFFFF;
        VAL_ZERO: v = 16'h0000;
        default: begin
          n = $urandom_range(7);
          v = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom_range(65535));
        end
      endcase
      f.push_back(v[15:8]);
      f.push_back(v[7:0]);
    end
    for (int k = 16; k < CHECKED_BYTES; k++) f.push_back(8'($urandom_range(255)));
    word = checksum_of(f);
    f.push_back(word[15:8]);
    f.push_back(word[7:0]);
    case (kind)
      CHUNK_BAD_SUM: begin
        idx = CHECKED_BYTES + $urandom_range(1);
        f[idx] ^= 8'($urandom_range(1, 255));
      end
      CHUNK_BAD_HDR: begin
        idx = $urandom_range(3);
        f[idx] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(1) == 1) begin
          word = checksum_of(f);
          f[30] = word[15:8];
          f[31] = word[7:0];
        end
      end
      CHUNK_SHORT: begin
        n = $urandom_range(1, FRAME_BYTES - 1);
        while (f.size() > n) void'(f.pop_back());
      end
      CHUNK_LONG: repeat ($urandom_range(1, 40)) f.push_back(8'($urandom_range(255)));
      CHUNK_NOISE: begin
        f.delete();
        repeat ($urandom_range(1, 70)) f.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    for (int k = 0; k < f.size(); k++) send_byte(f[k], k == f.size() - 1);
  endtask

  task automatic run_random(input int n_bytes);
    int          start;
    int          r;
    chunk_kind_t kind;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      r = $urandom_range(99);
      if (r < 55) kind = CHUNK_GOOD;
      else if (r < 67) kind = CHUNK_BAD_SUM;
      else if (r < 78) kind = CHUNK_BAD_HDR;
      else if (r < 86) kind = CHUNK_SHORT;
      else if (r < 93) kind = CHUNK_LONG;
      else kind = CHUNK_NOISE;
      send_chunk(kind, VAL_RANDOM);
    end
  endtask

  // stop sending and let every outstanding report come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_samples(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SPA_ADDR;
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_cycles = 0;
    bytes_sent = 0;
    snd_idle_pct = 35;
    rcv_idle_pct = 65;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-byte chunk, full-scale and all-zero frames, an overlong chunk
    send_byte(HEADER_0, 1'b1);
    send_chunk(CHUNK_GOOD, VAL_MAX);
    send_chunk(CHUNK_GOOD, VAL_ZERO);
    send_chunk(CHUNK_LONG, VAL_RANDOM);
    drain_reports();
    write_samples(8'd0);
    send_chunk(CHUNK_GOOD, VAL_RANDOM);
    send_chunk(CHUNK_BAD_HDR, VAL_RANDOM);
    send_chunk(CHUNK_GOOD, VAL_RANDOM);
    drain_reports();

    write_samples(8'd3);
    hold_cycles = 400;
    run_random(200);
    drain_reports();

    snd_idle_pct = 65;
    rcv_idle_pct = 35;
    write_samples(8'd255);
    repeat (20) send_chunk(CHUNK_GOOD, VAL_MAX);
    send_chunk(CHUNK_BAD_SUM, VAL_MAX);
    drain_reports();
    // lowered below the frames already summed
    write_samples(8'd2);
    run_random(200);
    drain_reports();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_samples(8'd7);
    run_random(200);
    drain_reports();

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
